@@ src/sktsi_pkg.sv @@
// shared types and constants for the sorted key table search and insert unit
`default_nettype none

package sktsi_pkg;

  localparam int TABLE_DEPTH_DEF  = 64;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int KEY_BITS         = 37;
  localparam int STATUS_BITS      = 3;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

endpackage

`default_nettype wire

@@ src/sktsi_table_mem.sv @@
// entry memory: one write port, one read port with registered read data
`default_nettype none

module sktsi_table_mem
  import sktsi_pkg::*;
#(
  parameter int DEPTH  = TABLE_DEPTH_DEF,
  parameter int WIDTH  = KEY_BITS + PAYLOAD_BITS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/sktsi_ctrl.sv @@
// sequencer: binary search, match check and shift-up insert over the entry memory
`default_nettype none

module sktsi_ctrl
  import sktsi_pkg::*;
#(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  parameter int IDX_W        = $clog2(TABLE_DEPTH),
  parameter int CNT_W        = $clog2(TABLE_DEPTH + 1),
  parameter int ENT_W        = KEY_BITS + PAYLOAD_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_mode,
  input  wire logic [KEY_BITS-1:0]     in_key,
  input  wire logic [PAYLOAD_BITS-1:0] in_pay,
  output logic                         res_valid,
  input  wire logic                    res_ready,
  output status_t                      res_status,
  output logic      [IDX_W-1:0]        res_pos,
  output logic      [PAYLOAD_BITS-1:0] res_pay,
  output logic      [CNT_W-1:0]        res_held,
  output logic                         mem_we,
  output logic      [IDX_W-1:0]        mem_waddr,
  output logic      [ENT_W-1:0]        mem_wdata,
  output logic                         mem_re,
  output logic      [IDX_W-1:0]        mem_raddr,
  input  wire logic [ENT_W-1:0]        mem_rdata
);

  typedef enum logic [2:0] {
    IDLE,
    SRCH_RD,
    SRCH_CMP,
    CHECK,
    SHIFT,
    DONE
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic                     mode_q;
  logic [KEY_BITS-1:0]      key_q;
  logic [PAYLOAD_BITS-1:0]  pay_q;
  logic [CNT_W-1:0]         lo;
  logic [CNT_W-1:0]         hi;
  logic [IDX_W-1:0]         mid_q;
  logic [IDX_W-1:0]         sh;
  logic [IDX_W-1:0]         last_rd;
  logic                     rd_more;
  logic                     rd_live;

  logic [CNT_W-1:0]         mid;
  logic [CNT_W-1:0]         cnt_m1;
  logic [IDX_W-1:0]         lo_idx;
  logic [KEY_BITS-1:0]      rkey;
  logic [PAYLOAD_BITS-1:0]  rpay;
  logic                     in_range;
  logic                     hit;

  assign mid      = lo + ((hi - lo) >> 1);
  assign cnt_m1   = count - CNT_W'(1);
  assign lo_idx   = lo[IDX_W-1:0];
  assign rkey     = mem_rdata[KEY_BITS-1:0];
  assign rpay     = mem_rdata[KEY_BITS +: PAYLOAD_BITS];
  assign in_range = (lo < count);
  assign hit      = in_range && (rkey == key_q);

  assign in_ready  = (state == IDLE);
  assign res_valid = (state == DONE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      SRCH_RD: begin
        if (lo < hi) begin
          mem_re    = 1'b1;
          mem_raddr = mid[IDX_W-1:0];
        end else if (in_range) begin
          mem_re    = 1'b1;
          mem_raddr = lo_idx;
        end
      end
      SHIFT: begin
        // move the word read last cycle up one place, then drop the new entry in
        if (rd_live) begin
          mem_we    = 1'b1;
          mem_waddr = last_rd + IDX_W'(1);
          mem_wdata = mem_rdata;
        end else if (!rd_more) begin
          mem_we    = 1'b1;
          mem_waddr = lo_idx;
          mem_wdata = {pay_q, key_q};
        end
        if (rd_more) begin
          mem_re    = 1'b1;
          mem_raddr = sh;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      count   <= '0;
      rd_more <= 1'b0;
      rd_live <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            mode_q <= in_mode;
            key_q  <= in_key;
            pay_q  <= in_pay;
            lo     <= '0;
            hi     <= count;
            state  <= SRCH_RD;
          end
        end
        SRCH_RD: begin
          if (lo < hi) begin
            mid_q <= mid[IDX_W-1:0];
            state <= SRCH_CMP;
          end else begin
            state <= CHECK;
          end
        end
        SRCH_CMP: begin
          if (rkey < key_q) begin
            lo <= CNT_W'(mid_q) + CNT_W'(1);
          end else begin
            hi <= CNT_W'(mid_q);
          end
          state <= SRCH_RD;
        end
        CHECK: begin
          res_held <= count;
          if (mode_q == MODE_LOOKUP) begin
            if (hit) begin
              res_status <= ST_FOUND;
              res_pos    <= lo_idx;
              res_pay    <= rpay;
            end else begin
              res_status <= ST_NOT_FOUND;
              res_pos    <= '0;
              res_pay    <= '0;
            end
            state <= DONE;
          end else if (hit) begin
            res_status <= ST_DUPLICATE;
            res_pos    <= '0;
            res_pay    <= '0;
            state      <= DONE;
          end else if (count == CNT_W'(TABLE_DEPTH)) begin
            res_status <= ST_FULL;
            res_pos    <= '0;
            res_pay    <= '0;
            state      <= DONE;
          end else begin
            rd_more <= in_range;
            rd_live <= 1'b0;
            sh      <= cnt_m1[IDX_W-1:0];
            state   <= SHIFT;
          end
        end
        SHIFT: begin
          if (rd_more) begin
            last_rd <= sh;
            rd_live <= 1'b1;
            if (sh == lo_idx) begin
              rd_more <= 1'b0;
            end else begin
              sh <= sh - IDX_W'(1);
            end
          end else begin
            rd_live <= 1'b0;
          end
          if (!rd_more && !rd_live) begin
            count      <= count + CNT_W'(1);
            res_status <= ST_INSERTED;
            res_pos    <= lo_idx;
            res_pay    <= '0;
            res_held   <= count + CNT_W'(1);
            state      <= DONE;
          end
        end
        DONE: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/sorted_key_table_search_insert_unit.sv @@
// Sorted key table with binary-search lookup and ordered insert.
// Input stream: s_axis_tuser carries the mode (0 lookup, 1 insert), s_axis_tdata
// the key and the payload handle. Each accepted word gives exactly one result
// word on the m_axis side: status in m_axis_tuser, and position, found payload
// and the entry count after the item in m_axis_tdata.
// One word is worked on at a time. Each binary search step is a memory read
// (SRCH_RD) then a compare (SRCH_CMP); a final read of the found place (when it
// lies inside the held entries), the match check and the output register follow
// before a lookup result is valid. An insert then shifts entries up, one entry
// moved per cycle through the single-port-pair entry memory, from the last held
// entry down to the insert position, and writes the new entry there last.
// The next word is accepted once the result has entered the output register.
// The result sits in an output register, so a new word is accepted while the
// previous result waits; if the receiver stalls, the next result is held inside
// and no further word is accepted until the output register frees up.
// Reset empties the table (entry count zero) at once; no clearing pass is needed
// since only entries below the count are ever read.
`default_nettype none

module sorted_key_table_search_insert_unit
  import sktsi_pkg::*;
#(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int IDX_W       = $clog2(TABLE_DEPTH),
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1),
  localparam int ENT_W       = KEY_BITS + PAYLOAD_BITS,
  localparam int S_DATA_W    = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
  localparam int M_DATA_W    = ((IDX_W + PAYLOAD_BITS + CNT_W + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // search_key, new_payload, zero fill
  input  wire logic [S_DATA_W-1:0]    s_axis_tdata,
  // mode
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // position, found_payload, entries_held, zero fill
  output logic      [M_DATA_W-1:0]    m_axis_tdata,
  // status
  output logic      [STATUS_BITS-1:0] m_axis_tuser
);

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [ENT_W-1:0]        mem_wdata;
  logic                    mem_re;
  logic [IDX_W-1:0]        mem_raddr;
  logic [ENT_W-1:0]        mem_rdata;

  logic                    res_valid;
  logic                    res_ready;
  status_t                 res_status;
  logic [IDX_W-1:0]        res_pos;
  logic [PAYLOAD_BITS-1:0] res_pay;
  logic [CNT_W-1:0]        res_held;

  sktsi_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENT_W),
    .ADDR_W(IDX_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  sktsi_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W),
    .ENT_W       (ENT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .in_key    (s_axis_tdata[KEY_BITS-1:0]),
    .in_pay    (s_axis_tdata[KEY_BITS +: PAYLOAD_BITS]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_status(res_status),
    .res_pos   (res_pos),
    .res_pay   (res_pay),
    .res_held  (res_held),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register frees up when empty or being taken this cycle
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= M_DATA_W'({res_held, res_pay, res_pos});
      m_axis_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire

@@ src/sktsi_checker.sv @@
// port-level checks on the result stream, bound to the top level
`default_nettype none

module sktsi_checker
  import sktsi_pkg::*;
#(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int IDX_W       = $clog2(TABLE_DEPTH),
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1),
  localparam int M_DATA_W    = ((IDX_W + PAYLOAD_BITS + CNT_W + 7) / 8) * 8
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [M_DATA_W-1:0]    m_axis_tdata,
  input wire logic [STATUS_BITS-1:0] m_axis_tuser
);

  logic [IDX_W-1:0]        pos;
  logic [PAYLOAD_BITS-1:0] pay;
  logic [CNT_W-1:0]        held;

  assign pos  = m_axis_tdata[IDX_W-1:0];
  assign pay  = m_axis_tdata[IDX_W +: PAYLOAD_BITS];
  assign held = m_axis_tdata[IDX_W + PAYLOAD_BITS +: CNT_W];

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // only a hit carries a payload
  a_pay_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_FOUND) |-> (pay == '0))
    else $error("payload set on a result that is not a hit");

  // rejections and misses report position zero
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_DUPLICATE || m_axis_tuser == ST_NOT_FOUND ||
                      m_axis_tuser == ST_FULL) |-> (pos == '0))
    else $error("position set on a rejected or missed word");

  // an inserted or found entry lies inside the held range
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_INSERTED || m_axis_tuser == ST_FOUND) |->
      (CNT_W'(pos) < held))
    else $error("position outside the held entries");

  // a full report only comes with a full table
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> (held == CNT_W'(TABLE_DEPTH)))
    else $error("table full reported below capacity");

endmodule

bind sorted_key_table_search_insert_unit sktsi_checker #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .PAYLOAD_BITS(PAYLOAD_BITS)
) u_sktsi_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
